// ----- rtl/core/pli_pkg.sv -----
package pli_pkg;

    // Largest number of entries the list can hold (1 to 64).
    localparam int CAPACITY = 16;

    localparam int DATA_W = 32;
    localparam int POS_W  = 8;
    localparam int LEN_W  = 7;
    localparam int REQ_W  = 2;
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd2;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] element;
        logic                     element_valid;
        logic                     last;
        logic [LEN_W-1:0]         length;
        logic                     is_empty;
    } result_t;

endpackage

// ----- rtl/core/pli_ram.sv -----
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/pli_out.sv -----
module pli_out (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  pli_pkg::result_t                 res,
    output logic                             slot_free,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             ok,
    output logic signed [pli_pkg::DATA_W-1:0] element,
    output logic                             element_valid,
    output logic                             last,
    output logic [pli_pkg::LEN_W-1:0]        length,
    output logic                             is_empty
);
    import pli_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // The slot can take a new result when empty or when its result leaves now.
    assign slot_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = valid_reg;
    assign ok            = res_reg.ok;
    assign element       = res_reg.element;
    assign element_valid = res_reg.element_valid;
    assign last          = res_reg.last;
    assign length        = res_reg.length;
    assign is_empty      = res_reg.is_empty;

endmodule

// ----- rtl/core/positional_list_insert_delete.sv -----
// Positional list: an ordered list of signed 32-bit entries held in a small
// synchronous RAM, with a count kept in a register.
//
// Input channel (in_valid / in_stall): one request per handshake: insert (value
// at a one-based position), delete (entry at a one-based position) or dump
// (every entry in order). The block takes one request at a time and holds
// in_stall high until that request has handed its last result to the output
// register. Output channel (out_valid / out_stall): a registered result slot;
// a dump of N > 0 entries gives N results, every other request gives one.
//
// Sequence from acceptance: an insert or delete that moves M > 0 entries
// does one RAM read and one write per moved entry, each write following its
// read, and an insert then writes its value into the slot before the result
// is loaded. A rejected request goes straight to its result, with no RAM
// access. A dump loads one result per cycle while the output slot is free,
// the first once the registered RAM read of the first entry is back.
//
// Reset clears the count and the control state but not the RAM, as only
// entries below the count are ever read. When the receiver stalls, the result
// waits in the output register and a dump pauses without further RAM reads.
module positional_list_insert_delete (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [pli_pkg::REQ_W-1:0]         req_type,
    input  logic [pli_pkg::POS_W-1:0]         position,
    input  logic signed [pli_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              ok,
    output logic signed [pli_pkg::DATA_W-1:0] element,
    output logic                              element_valid,
    output logic                              last,
    output logic [pli_pkg::LEN_W-1:0]         length,
    output logic                              is_empty
);
    import pli_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SHIFT  = 4'b0010,
        ST_RESULT = 4'b0100,
        ST_DUMP   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    count_reg, count_next;
    logic [LEN_W-1:0]    moves_reg, moves_next;
    logic [ADDR_W-1:0]   src_reg, src_next;
    logic [ADDR_W-1:0]   slot_reg, slot_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic                is_ins_reg, is_ins_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   pend_dst_reg, pend_dst_next;
    logic                res_ok_reg, res_ok_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;

    logic                accept;
    logic [POS_W:0]      pos_ext;
    logic [POS_W:0]      cnt_ext;
    logic [POS_W-1:0]    pos_m1;
    logic                ins_ok;
    logic                del_ok;
    logic                dump_last;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [DATA_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [DATA_W-1:0]   ram_rd_data;

    logic                slot_free;
    logic                out_load;
    result_t             out_res;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    // Range checks use the count before the request.
    assign pos_ext = {1'b0, position};
    assign cnt_ext = {{(POS_W + 1 - LEN_W){1'b0}}, count_reg};
    assign pos_m1  = position - POS_W'(1);
    assign ins_ok  = (position != '0) && (pos_ext <= cnt_ext + (POS_W + 1)'(1))
                     && (count_reg < LEN_W'(CAPACITY));
    assign del_ok  = (position != '0) && (pos_ext <= cnt_ext);

    assign dump_last = ({{(LEN_W - ADDR_W){1'b0}}, idx_reg} + LEN_W'(1)) == count_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        moves_next    = moves_reg;
        src_next      = src_reg;
        slot_next     = slot_reg;
        val_next      = val_reg;
        is_ins_next   = is_ins_reg;
        pend_next     = pend_reg;
        pend_dst_next = pend_dst_reg;
        res_ok_next   = res_ok_reg;
        idx_next      = idx_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = pend_dst_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = src_reg;

        out_load              = 1'b0;
        out_res.ok            = res_ok_reg;
        out_res.element       = '0;
        out_res.element_valid = 1'b0;
        out_res.last          = 1'b1;
        out_res.length        = count_reg;
        out_res.is_empty      = (count_reg == '0);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    slot_next   = pos_m1[ADDR_W-1:0];
                    val_next    = value;
                    pend_next   = 1'b0;
                    res_ok_next = 1'b0;
                    state_next  = ST_RESULT;
                    if ((req_type == REQ_INSERT) && ins_ok)
                    begin
                        // Entries from the old tail down to the slot move up.
                        is_ins_next = 1'b1;
                        count_next  = count_reg + LEN_W'(1);
                        moves_next  = LEN_W'(cnt_ext + (POS_W + 1)'(1) - pos_ext);
                        src_next    = ADDR_W'(count_reg - LEN_W'(1));
                        state_next  = ST_SHIFT;
                    end
                    else if ((req_type == REQ_DELETE) && del_ok)
                    begin
                        // Entries after the slot move down by one.
                        is_ins_next = 1'b0;
                        count_next  = count_reg - LEN_W'(1);
                        moves_next  = LEN_W'(cnt_ext - pos_ext);
                        src_next    = position[ADDR_W-1:0];
                        state_next  = ST_SHIFT;
                    end
                    else if (req_type == REQ_DUMP)
                    begin
                        res_ok_next = 1'b1;
                        if (count_reg != '0)
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = '0;
                            idx_next    = '0;
                            state_next  = ST_DUMP;
                        end
                    end
                end
            end

            ST_SHIFT:
            begin
                // Write back the entry read in the previous cycle.
                if (pend_reg)
                begin
                    ram_wr_en = 1'b1;
                end
                if (moves_reg != '0)
                begin
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = src_reg;
                    pend_next     = 1'b1;
                    pend_dst_next = is_ins_reg ? src_reg + ADDR_W'(1) : src_reg - ADDR_W'(1);
                    src_next      = is_ins_reg ? src_reg - ADDR_W'(1) : src_reg + ADDR_W'(1);
                    moves_next    = moves_reg - LEN_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        // All moves are done; an insert now fills its slot.
                        if (is_ins_reg)
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = slot_reg;
                            ram_wr_data = val_reg;
                        end
                        res_ok_next = 1'b1;
                        state_next  = ST_RESULT;
                    end
                end
            end

            ST_RESULT:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_DUMP:
            begin
                out_res.ok            = 1'b1;
                out_res.element       = $signed(ram_rd_data);
                out_res.element_valid = 1'b1;
                out_res.last          = dump_last;
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (dump_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx_reg + ADDR_W'(1);
                        idx_next    = idx_reg + ADDR_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        moves_reg    <= moves_next;
        src_reg      <= src_next;
        slot_reg     <= slot_next;
        val_reg      <= val_next;
        is_ins_reg   <= is_ins_next;
        pend_dst_reg <= pend_dst_next;
        res_ok_reg   <= res_ok_next;
        idx_reg      <= idx_next;
    end

    pli_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    pli_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .res           (out_res),
        .slot_free     (slot_free),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ok            (ok),
        .element       (element),
        .element_valid (element_valid),
        .last          (last),
        .length        (length),
        .is_empty      (is_empty)
    );

endmodule

// ----- test/positional_list_insert_delete_test.sv -----
module positional_list_insert_delete_test;

    import pli_pkg::*;

    // The request type that the block does not define; it must be rejected.
    localparam logic [REQ_W-1:0] REQ_UNDEFINED = 2'd3;

    // Longest stretch of cycles with no request and no result moving before
    // the run is declared hung. The slowest correct request (a 15-entry shift
    // behind the largest sender gap and receiver stall) stays far below this.
    localparam int WATCHDOG_LIMIT = 1000;

    // Cycles to wait after the last expected result, so that a stray extra
    // result still has time to show up and be flagged.
    localparam int DRAIN_CYCLES = 64;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [REQ_W-1:0]         req_type = '0;
    logic [POS_W-1:0]         position = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     ok;
    logic signed [DATA_W-1:0] element;
    logic                     element_valid;
    logic                     last;
    logic [LEN_W-1:0]         length;
    logic                     is_empty;

    // Shadow copy of the list contents, in list order, and the results that
    // the block still owes us, oldest first.
    logic signed [DATA_W-1:0] shadow_list[$];
    result_t                  pending_results[$];
    result_t                  wanted;

    // Idling controls: the largest gap the sender leaves before a request and
    // the largest stall the receiver holds before taking a result.
    int gap_max = 0;
    int stall_max = 0;
    int stall_left = 0;

    int mismatch_count = 0;
    int results_checked = 0;
    int quiet_cycles = 0;
    int insert_count = 0;
    int delete_count = 0;
    int dump_count = 0;
    int undefined_count = 0;
    int reject_count = 0;
    int longest_list = 0;

    positional_list_insert_delete i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .position     (position),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ok           (ok),
        .element      (element),
        .element_valid(element_valid),
        .last         (last),
        .length       (length),
        .is_empty     (is_empty)
    );

    always #2 clk = ~clk;

    // Builds one result as the block should report it, with the length and
    // the empty flag taken from the shadow list as it stands now.
    function automatic result_t list_result(input logic ok_bit,
                                            input logic signed [DATA_W-1:0] elem,
                                            input logic elem_valid,
                                            input logic last_bit);
        result_t r;
        r.ok            = ok_bit;
        r.element       = elem;
        r.element_valid = elem_valid;
        r.last          = last_bit;
        r.length        = LEN_W'(shadow_list.size());
        r.is_empty      = (shadow_list.size() == 0);
        return r;
    endfunction

    // Applies one accepted request to the shadow list and queues the results
    // it must produce. Inserts, deletes and undefined types give one status result;
    // a dump gives one result per entry, or a single empty marker for an empty list.
    task automatic predict_request(input logic [REQ_W-1:0] kind,
                                   input logic [POS_W-1:0] pos,
                                   input logic signed [DATA_W-1:0] val);
        int  len;
        int  slot;
        logic done;
        len  = shadow_list.size();
        slot = int'(pos);
        done = 1'b0;
        case (kind)
            REQ_INSERT:
            begin
                insert_count++;
                // Position must lie in 1..length+1 and there must be room left.
                if (slot != 0 && slot <= len + 1 && len < CAPACITY)
                begin
                    shadow_list.insert(slot - 1, val);
                    done = 1'b1;
                end
                pending_results.push_back(list_result(done, '0, 1'b0, 1'b1));
            end
            REQ_DELETE:
            begin
                delete_count++;
                // Position must name an existing entry, 1..length.
                if (slot != 0 && slot <= len)
                begin
                    shadow_list.delete(slot - 1);
                    done = 1'b1;
                end
                pending_results.push_back(list_result(done, '0, 1'b0, 1'b1));
            end
            REQ_DUMP:
            begin
                dump_count++;
                done = 1'b1;
                if (len == 0)
                begin
                    pending_results.push_back(list_result(1'b1, '0, 1'b0, 1'b1));
                end
                else
                begin
                    for (int i = 0; i < len; i++)
                    begin
                        pending_results.push_back(
                            list_result(1'b1, shadow_list[i], 1'b1, i == len - 1));
                    end
                end
            end
            default:
            begin
                undefined_count++;
                pending_results.push_back(list_result(1'b0, '0, 1'b0, 1'b1));
            end
        endcase
        if (!done)
        begin
            reject_count++;
        end
        if (shadow_list.size() > longest_list)
        begin
            longest_list = shadow_list.size();
        end
    endtask

    // Sends one request. It is entered and left at a falling edge. A random
    // gap of idle cycles comes first; with no gap, valid simply stays high
    // from the previous request, so it is never dropped and raised in one step.
    task automatic send_request(input logic [REQ_W-1:0] kind,
                                input logic [POS_W-1:0] pos,
                                input logic signed [DATA_W-1:0] val);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        position <= pos;
        value    <= val;
        // Wait for the edge that takes the request.
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predict_request(kind, pos, val);
        @(negedge clk);
    endtask

    // The receiver holds stall for a freshly drawn number of cycles after
    // each result it takes, so stalls land on every phase of the block's work.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Result checker: every result taken is compared field by field with the
    // oldest expectation. Values sampled here are those from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            stall_left = $urandom_range(0, stall_max);
            results_checked++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("ERROR: unexpected result ok=%0b element=%0d valid=%0b last=%0b",
                             ok, element, element_valid, last);
                end
            end
            else
            begin
                wanted = pending_results.pop_front();
                if (ok !== wanted.ok || element !== wanted.element
                    || element_valid !== wanted.element_valid || last !== wanted.last
                    || length !== wanted.length || is_empty !== wanted.is_empty)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("ERROR: result %0d expected ok=%0b element=%0d valid=%0b",
                                 results_checked, wanted.ok, wanted.element,
                                 wanted.element_valid);
                        $display("       last=%0b length=%0d empty=%0b; got ok=%0b element=%0d",
                                 wanted.last, wanted.length, wanted.is_empty, ok, element);
                        $display("       valid=%0b last=%0b length=%0d empty=%0b",
                                 element_valid, last, length, is_empty);
                    end
                end
            end
        end
    end

    // Watchdog: any cycle in which a request or a result moves resets the
    // count; a long silence means the block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: nothing moved for %0d cycles, %0d results outstanding.",
                         quiet_cycles, pending_results.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // An empty list: dump gives a single empty marker, position zero and
    // positions past the end are refused, and the undefined type is refused
    // with every position and value bit set.
    task automatic test_empty_list();
        gap_max   = 14;
        stall_max = 14;
        send_request(REQ_DUMP, '0, '0);
        send_request(REQ_DELETE, 8'd0, '0);
        send_request(REQ_INSERT, 8'd0, 32'sd5);
        send_request(REQ_INSERT, 8'd2, 32'sd6);
        send_request(REQ_UNDEFINED, 8'd255, -32'sd1);
    endtask

    // Inserts at the front and at the end with the most negative and most
    // positive values, an insert far past the end, and deletes of the last
    // and the first entries.
    task automatic test_boundary_positions();
        gap_max   = 2;
        stall_max = 0;
        send_request(REQ_INSERT, 8'd1, 32'sh8000_0000);
        send_request(REQ_INSERT, 8'd2, 32'sh7FFF_FFFF);
        send_request(REQ_INSERT, 8'd1, 32'sd0);
        send_request(REQ_INSERT, 8'd255, 32'sd1);
        send_request(REQ_DELETE, 8'd3, '0);
        send_request(REQ_DELETE, 8'd1, '0);
    endtask

    // Fills the list to capacity, alternating between the front and the end,
    // then tries one more insert and dumps the full list back-to-back.
    task automatic test_full_list();
        logic [POS_W-1:0] pos;
        gap_max   = 0;
        stall_max = 3;
        while (shadow_list.size() < CAPACITY)
        begin
            pos = (shadow_list.size() % 2 == 0) ? POS_W'(shadow_list.size() + 1) : 8'd1;
            send_request(REQ_INSERT, pos, $urandom);
        end
        send_request(REQ_INSERT, 8'd1, -32'sd7);
        send_request(REQ_DUMP, '0, '0);
    endtask

    // Random traffic: mostly well-formed inserts and deletes at legal
    // positions with random values, some dumps, and some noise with random
    // types and positions. grow_pct sets how much of the well-formed part is
    // inserts, so some phases drive the list full and others drain it.
    task automatic random_requests(input int count, input int gap_limit,
                                   input int stall_limit, input int grow_pct);
        int                       roll;
        int                       len;
        logic [REQ_W-1:0]         kind;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        gap_max   = gap_limit;
        stall_max = stall_limit;
        repeat (count)
        begin
            len  = shadow_list.size();
            roll = $urandom_range(0, 99);
            pos  = POS_W'($urandom_range(0, 255));
            case ($urandom_range(0, 9))
                0:       val = 32'sh8000_0000;
                1:       val = 32'sh7FFF_FFFF;
                2:       val = 32'sd0;
                3:       val = -32'sd1;
                default: val = $urandom;
            endcase
            if (roll < 10)
            begin
                kind = REQ_W'($urandom_range(0, 3));
            end
            else if (roll < 20)
            begin
                kind = REQ_DUMP;
            end
            else if (roll < 20 + grow_pct * 80 / 100)
            begin
                kind = REQ_INSERT;
                pos  = POS_W'($urandom_range(1, len + 1));
            end
            else
            begin
                kind = REQ_DELETE;
                if (len > 0)
                begin
                    pos = POS_W'($urandom_range(1, len));
                end
            end
            send_request(kind, pos, val);
        end
    endtask

    task automatic test_random_traffic();
        random_requests(48, 0, 0, 75);
        random_requests(48, 14, 14, 50);
        random_requests(48, 4, 0, 30);
        random_requests(48, 0, 14, 65);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_list();
        test_boundary_positions();
        test_full_list();
        test_random_traffic();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d inserts, %0d deletes, %0d dumps and %0d undefined requests;",
                 insert_count, delete_count, dump_count, undefined_count);
        $display("%0d were refused, the list reached %0d entries, %0d results were checked.",
                 reject_count, longest_list, results_checked);
        if (mismatch_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("%0d mismatching results.", mismatch_count);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/pli_pkg.sv
rtl/core/pli_ram.sv
rtl/core/pli_out.sv
rtl/core/positional_list_insert_delete.sv
test/positional_list_insert_delete_test.sv
